// File: rtl/core/breathing_led_phase_generator_assert.svh
// Assertion macros used by the checker file.
`ifndef BREATHING_LED_PHASE_GENERATOR_ASSERT_SVH
`define BREATHING_LED_PHASE_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BPLG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bplg check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BPLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bplg check failed");

`endif

// File: rtl/core/bplg_pkg.sv
package bplg_pkg;

  localparam int PhaseW   = 11;
  localparam int LevelW   = 8;
  localparam int LimitW   = 10;
  localparam int DutyW    = 7;
  localparam int CosW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;

  localparam int PhaseLenDefault   = 2048;
  localparam int CosEntriesDefault = 256;
  localparam int QueueDepth        = 2;

  localparam logic [CfgIdxW-1:0] CfgPhaseStep   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLowLevel    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHighLevel   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLimitedHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgColorLimit  = 3'd4;

  localparam logic [PhaseW-1:0] PhaseStepReset   = 11'd16;
  localparam logic [LevelW-1:0] LowLevelReset    = 8'd10;
  localparam logic [LevelW-1:0] HighLevelReset   = 8'd255;
  localparam logic [LevelW-1:0] LimitedHighReset = 8'd55;
  localparam logic [LimitW-1:0] ColorLimitReset  = 10'd255;

  localparam logic [DutyW-1:0] DutyMax = 7'd100;

  localparam longint unsigned Q30One    = 64'd1073741824;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned Q30Mask   = 64'h3FFF_FFFF;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              over_limit;
  } job_t;

  typedef struct packed {
    logic [LevelW-1:0] low_level;
    logic [LevelW-1:0] high_level;
    logic [LevelW-1:0] limited_high;
  } level_cfg_t;

  function automatic logic signed [CosW-1:0] quarter_cos(longint unsigned u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = (u * HalfPiQ30) >> 30;
    x2   = (x * x) >> 30;
    term = Q30One;
    acc  = longint'(Q30One);
    term = ((term * x2) >> 30) / 2;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 12;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 30;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 56;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 90;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 132;
    acc  = acc + longint'(term);
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(Q30One)) begin
      acc = longint'(Q30One);
    end
    return CosW'(($unsigned(acc) + 64'd32768) >> 16);
  endfunction

  function automatic logic signed [CosW-1:0] cos_entry(int k, int idx_bits);
    longint unsigned a;
    longint unsigned r;
    logic [1:0]      quad;
    a    = $unsigned(longint'(k)) << (32 - idx_bits);
    quad = 2'((a >> 30) & 64'd3);
    r    = a & Q30Mask;
    case (quad)
      2'd0:    return quarter_cos(r);
      2'd1:    return -quarter_cos(Q30One - r);
      2'd2:    return -quarter_cos(r);
      default: return quarter_cos(Q30One - r);
    endcase
  endfunction

endpackage

// File: rtl/core/bplg_in_if.sv
interface bplg_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [bplg_pkg::PhaseW-1:0]  phase_value;
  logic                         in_sync;
  logic [bplg_pkg::LevelW-1:0]  color_red;
  logic [bplg_pkg::LevelW-1:0]  color_green;
  logic [bplg_pkg::LevelW-1:0]  color_blue;

  modport source (
    output valid, action, phase_value, in_sync, color_red, color_green, color_blue,
    input  ready
  );
  modport sink (
    input  valid, action, phase_value, in_sync, color_red, color_green, color_blue,
    output ready
  );
endinterface

// File: rtl/core/bplg_out_if.sv
interface bplg_out_if;
  logic                        valid;
  logic                        ready;
  logic [bplg_pkg::PhaseW-1:0] phase_now;
  logic [bplg_pkg::LevelW-1:0] brightness;
  logic [bplg_pkg::LevelW-1:0] limited_brightness;
  logic [bplg_pkg::DutyW-1:0]  duty_percent;

  modport source (
    output valid, phase_now, brightness, limited_brightness, duty_percent,
    input  ready
  );
  modport sink (
    input  valid, phase_now, brightness, limited_brightness, duty_percent,
    output ready
  );
endinterface

// File: rtl/core/bplg_queue.sv
module bplg_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bplg_pkg::job_t     job_i,
  output logic               full_o,
  input  logic               pop_i,
  output bplg_pkg::job_t     job_o,
  output logic               empty_o
);

  localparam int PtrW = (bplg_pkg::QueueDepth > 1) ? $clog2(bplg_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(bplg_pkg::QueueDepth + 1);

  bplg_pkg::job_t mem_q [bplg_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(bplg_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(bplg_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(bplg_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/core/bplg_front.sv
module bplg_front #(
  parameter int PHASE_LEN = bplg_pkg::PhaseLenDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bplg_in_if.sink                     req_i,
  input  logic [bplg_pkg::PhaseW-1:0] phase_step_i,
  input  logic [bplg_pkg::LimitW-1:0] color_limit_i,
  input  logic                        full_i,
  output logic                        push_o,
  output bplg_pkg::job_t              job_o
);

  localparam int PhaseLenW = $clog2(PHASE_LEN);
  localparam int WideW     = (PhaseLenW > bplg_pkg::PhaseW + 1) ? PhaseLenW
                                                                 : bplg_pkg::PhaseW + 1;
  localparam logic [WideW-1:0] PhaseMask = WideW'(PHASE_LEN - 1);

  logic [bplg_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [WideW-1:0]            adv_w;
  logic [WideW-1:0]            load_w;
  logic [bplg_pkg::LimitW-1:0] color_sum;
  logic                        accept;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && req_i.ready;

  assign adv_w     = (WideW'(phase_q) + WideW'(phase_step_i)) & PhaseMask;
  assign load_w    = WideW'(req_i.phase_value) & PhaseMask;
  assign color_sum = bplg_pkg::LimitW'(req_i.color_red) + bplg_pkg::LimitW'(req_i.color_green)
                   + bplg_pkg::LimitW'(req_i.color_blue);

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (req_i.action) begin
        phase_d = bplg_pkg::PhaseW'(load_w);
      end else if (req_i.in_sync) begin
        phase_d = bplg_pkg::PhaseW'(adv_w);
      end else begin
        phase_d = '0;
      end
    end
  end

  assign push_o           = accept && !req_i.action;
  assign job_o.phase      = phase_d;
  assign job_o.over_limit = (color_sum > color_limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// File: rtl/core/bplg_back.sv
module bplg_back #(
  parameter int PHASE_LEN   = bplg_pkg::PhaseLenDefault,
  parameter int COS_ENTRIES = bplg_pkg::CosEntriesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bplg_pkg::level_cfg_t cfg_i,
  input  logic                 empty_i,
  input  bplg_pkg::job_t       job_i,
  output logic                 pop_o,
  bplg_out_if.source           rsp_o
);

  localparam int PhaseLenW = $clog2(PHASE_LEN);
  localparam int IdxW      = $clog2(COS_ENTRIES);
  localparam int ExtW      = bplg_pkg::PhaseW + IdxW;
  localparam int TotW      = 27;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic signed [bplg_pkg::CosW-1:0] cos_rom [COS_ENTRIES];

  for (genvar k = 0; k < COS_ENTRIES; k++) begin : g_rom
    assign cos_rom[k] = bplg_pkg::cos_entry(k, IdxW);
  end

  logic [1:0]                       state_q, state_d;
  logic [bplg_pkg::PhaseW-1:0]      phase_q;
  logic                             over_q;
  logic signed [bplg_pkg::CosW-1:0] cos_q;
  logic signed [TotW-1:0]           tot_full_q, tot_lim_q;
  logic [bplg_pkg::LevelW-1:0]      full_q, lim_q;
  logic [bplg_pkg::DutyW-1:0]       duty_q;

  logic [ExtW-1:0]                  idx_ext;
  logic [IdxW-1:0]                  idx;
  logic signed [16:0]               weight;
  logic signed [8:0]                half_full, half_lim;
  logic signed [TotW-1:0]           base;
  logic signed [25:0]               prod_full, prod_lim;
  logic [bplg_pkg::LevelW-1:0]      full_lvl, lim_lvl;
  logic [14:0]                      duty_num;
  logic [15:0]                      duty_quo;
  logic [bplg_pkg::DutyW-1:0]       duty_lvl;

  function automatic logic signed [8:0] half_span(logic [7:0] peak, logic [7:0] low);
    logic signed [8:0] diff;
    diff = $signed({1'b0, peak}) - $signed({1'b0, low});
    return (diff + $signed({8'b0, diff[8]})) >>> 1;
  endfunction

  function automatic logic [7:0] clamp_level(logic signed [26:0] t);
    logic [11:0] v;
    v = t[25:14];
    if (t[26]) begin
      return '0;
    end else if (v > 12'd255) begin
      return 8'hFF;
    end
    return v[7:0];
  endfunction

  assign idx_ext = {job_i.phase, IdxW'(0)} >> PhaseLenW;
  assign idx     = idx_ext[IdxW-1:0];

  assign weight    = 17'sd16384 - {cos_q[bplg_pkg::CosW-1], cos_q};
  assign half_full = half_span(cfg_i.high_level, cfg_i.low_level);
  assign half_lim  = half_span(over_q ? cfg_i.limited_high : cfg_i.high_level, cfg_i.low_level);
  assign prod_full = weight * half_full;
  assign prod_lim  = weight * half_lim;
  assign base      = $signed({5'b0, cfg_i.low_level, 14'b0});

  assign full_lvl = clamp_level(tot_full_q);
  assign lim_lvl  = clamp_level(tot_lim_q);
  assign duty_num = 15'(full_lvl) * 15'd100;
  assign duty_quo = (16'(duty_num) + 16'(duty_num >> 8) + 16'd1) >> 8;
  assign duty_lvl = (duty_quo > 16'(bplg_pkg::DutyMax)) ? bplg_pkg::DutyMax
                                                         : duty_quo[bplg_pkg::DutyW-1:0];

  assign pop_o = (state_q == StIdle) && !empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StFin;
      end
      StFin: begin
        state_d = StOut;
      end
      StOut: begin
        if (rsp_o.ready) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      phase_q <= job_i.phase;
      over_q  <= job_i.over_limit;
      cos_q   <= cos_rom[idx];
    end
    if (state_q == StMul) begin
      tot_full_q <= base + TotW'(prod_full);
      tot_lim_q  <= base + TotW'(prod_lim);
    end
    if (state_q == StFin) begin
      full_q <= full_lvl;
      lim_q  <= lim_lvl;
      duty_q <= duty_lvl;
    end
  end

  assign rsp_o.valid              = (state_q == StOut);
  assign rsp_o.phase_now          = phase_q;
  assign rsp_o.brightness         = full_q;
  assign rsp_o.limited_brightness = lim_q;
  assign rsp_o.duty_percent       = duty_q;

endmodule

// File: rtl/core/breathing_led_phase_generator.sv
// Breathing-LED phase generator.
// Requests arrive on req_i (valid/ready). A tick request (action 0) advances the
// phase by phase_step when in_sync is set, else returns it to 0, and yields one
// response on rsp_o: the new phase, full and limited cosine brightness, and PWM
// duty percent. A load request (action 1) sets the phase and yields no response.
// Config is written via cfg_we_i / cfg_idx_i / cfg_wdata_i, one register per cycle;
// the user must write only while the block is idle; the block does not enforce it.
// The front stage updates the phase in the accept cycle and hands each tick to a
// two-entry queue; the back stage does table lookup, multiply and clamp.
// Each tick passes the queue, then the back stage's lookup, multiply and clamp
// registers before its response is valid; no new tick enters the back stage until
// the last one is handed off. Loads do not enter the queue.
// When the receiver stalls, the response holds; the queue takes up to two more
// ticks, then req_i.ready drops.
// Reset clears the phase to 0, empties the queue and restores all configuration
// registers to their defaults (step 16, low 10, high 255, limited 55, colour limit 255).
module breathing_led_phase_generator #(
  parameter int PHASE_LEN   = bplg_pkg::PhaseLenDefault,
  parameter int COS_ENTRIES = bplg_pkg::CosEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bplg_in_if.sink                       req_i,
  bplg_out_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [bplg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bplg_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [bplg_pkg::PhaseW-1:0] phase_step_q;
  logic [bplg_pkg::LimitW-1:0] color_limit_q;
  bplg_pkg::level_cfg_t        level_cfg_q;

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  bplg_pkg::job_t job_in;
  bplg_pkg::job_t job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q             <= bplg_pkg::PhaseStepReset;
      level_cfg_q.low_level    <= bplg_pkg::LowLevelReset;
      level_cfg_q.high_level   <= bplg_pkg::HighLevelReset;
      level_cfg_q.limited_high <= bplg_pkg::LimitedHighReset;
      color_limit_q            <= bplg_pkg::ColorLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bplg_pkg::CfgPhaseStep:   phase_step_q <= cfg_wdata_i[bplg_pkg::PhaseW-1:0];
        bplg_pkg::CfgLowLevel:    level_cfg_q.low_level <= cfg_wdata_i[bplg_pkg::LevelW-1:0];
        bplg_pkg::CfgHighLevel:   level_cfg_q.high_level <= cfg_wdata_i[bplg_pkg::LevelW-1:0];
        bplg_pkg::CfgLimitedHigh: level_cfg_q.limited_high <= cfg_wdata_i[bplg_pkg::LevelW-1:0];
        bplg_pkg::CfgColorLimit:  color_limit_q <= cfg_wdata_i[bplg_pkg::LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  bplg_front #(
    .PHASE_LEN (PHASE_LEN)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .phase_step_i  (phase_step_q),
    .color_limit_i (color_limit_q),
    .full_i        (full),
    .push_o        (push),
    .job_o         (job_in)
  );

  bplg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty)
  );

  bplg_back #(
    .PHASE_LEN   (PHASE_LEN),
    .COS_ENTRIES (COS_ENTRIES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (level_cfg_q),
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

// File: rtl/core/bplg_checker.sv
`include "breathing_led_phase_generator_assert.svh"

module bplg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [bplg_pkg::PhaseW-1:0] phase_now_i,
  input logic [bplg_pkg::LevelW-1:0] brightness_i,
  input logic [bplg_pkg::LevelW-1:0] limited_i,
  input logic [bplg_pkg::DutyW-1:0]  duty_i
);

  logic [14:0] bright_x100;
  logic [14:0] duty_lo;
  logic [14:0] duty_hi;

  assign bright_x100 = 15'(brightness_i) * 15'd100;
  assign duty_lo     = 15'(duty_i) * 15'd255;
  assign duty_hi     = 15'(duty_i) * 15'd255 + 15'd255;

  `BPLG_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `BPLG_ASSERT_NEXT(a_payload_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(phase_now_i) && $stable(brightness_i) && $stable(limited_i) && $stable(duty_i))
  `BPLG_ASSERT_IMP(a_duty_matches, clk_i, rst_ni, out_valid_i, duty_lo <= bright_x100 && bright_x100 < duty_hi)
  `BPLG_ASSERT_IMP(a_duty_capped, clk_i, rst_ni, out_valid_i, duty_i <= bplg_pkg::DutyMax)

endmodule

bind breathing_led_phase_generator bplg_checker u_bplg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .phase_now_i (rsp_o.phase_now),
  .brightness_i(rsp_o.brightness),
  .limited_i   (rsp_o.limited_brightness),
  .duty_i      (rsp_o.duty_percent)
);
